// ===== rtl/sll_pkg.sv =====
// ----------------------------------------------------------------------------
// sll_pkg
// Shared constants, codes, types and helpers of the static linked list engine.
// ----------------------------------------------------------------------------
package sll_pkg;

    localparam int NODES = 16;
    localparam int IDX_W = $clog2(NODES);
    localparam int KEY_W = 56;
    localparam int ACT_W = 2;
    localparam int ST_W  = 2;

    // node 0 heads the free chain, node 1 heads the list
    localparam logic [IDX_W-1:0] FREE_NODE = '0;
    localparam logic [IDX_W-1:0] HEAD_NODE = IDX_W'(1);
    localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODES - 1);

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {RA_FREE, RA_HEAD, RA_LINK, RA_POS} rd_addr_sel_t;
    typedef enum logic [1:0] {WA_FREE, WA_NODE, WA_PREV} wr_addr_sel_t;
    typedef enum logic [1:0] {WD_LINK, WD_NODE, WD_AUX} wr_data_sel_t;
    typedef enum logic [1:0] {RI_ZERO, RI_NODE, RI_RDADDR} res_idx_sel_t;
    typedef enum logic [2:0] {SC_HOLD, SC_LOAD, SC_CLEAR, SC_DEC, SC_INC} step_op_t;

    typedef struct packed {
        logic              load_item;
        logic              link_rd;
        logic              key_rd;
        rd_addr_sel_t      rd_sel;
        logic              link_wr;
        logic              key_wr;
        wr_addr_sel_t      wa_sel;
        wr_data_sel_t      wd_sel;
        logic              node_load;
        logic              aux_load;
        logic              prev_load;
        step_op_t          step_op;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              res_load;
        logic [ST_W-1:0]   res_status;
        res_idx_sel_t      res_idx;
        logic              res_data;
        logic              out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             ins_bad;
        logic             del_bad;
        logic             rd_bad;
        logic             link_zero;
        logic             key_match;
        logic             step_zero;
        logic             step_last;
        logic             out_free;
    } dp_status_t;

    // link held by a node that was never written since reset
    function automatic logic [IDX_W-1:0] link_reset(input logic [IDX_W-1:0] n);
        if (n == FREE_NODE)
            return HEAD_NODE + IDX_W'(1);
        else if (n == HEAD_NODE || n == LAST_NODE)
            return '0;
        else
            return n + IDX_W'(1);
    endfunction

endpackage

// ===== rtl/sll_req_if.sv =====
// ----------------------------------------------------------------------------
// sll_req_if
// Request channel: one list operation per item.
// ----------------------------------------------------------------------------
interface sll_req_if;
    logic                          valid;
    logic                          ready;
    logic [sll_pkg::ACT_W-1:0]     action;
    logic [sll_pkg::IDX_W-1:0]     position;
    logic [sll_pkg::KEY_W-1:0]     key;

    modport source (output valid, action, position, key, input ready);
    modport sink   (input valid, action, position, key, output ready);
endinterface

// ===== rtl/sll_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sll_rsp_if
// Response channel: one result item per request.
// ----------------------------------------------------------------------------
interface sll_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sll_pkg::ST_W-1:0]      status;
    logic [sll_pkg::IDX_W-1:0]     node_index;
    logic [sll_pkg::KEY_W-1:0]     node_key;
    logic [sll_pkg::IDX_W-1:0]     node_link;
    logic [sll_pkg::IDX_W-1:0]     list_count;

    modport source (output valid, status, node_index, node_key, node_link, list_count,
                    input ready);
    modport sink   (input valid, status, node_index, node_key, node_link, list_count,
                    output ready);
endinterface

// ===== rtl/static_linked_list_engine.sv =====
// ----------------------------------------------------------------------------
// static_linked_list_engine
// Singly linked list with a free chain inside a fixed node store.
// ----------------------------------------------------------------------------
//  channel    dir  fields                                            handshake
//  request    in   action, position, key                             valid/ready
//  response   out  status, node_index, node_key, node_link,          valid/ready
//                  list_count
//
//  One item at a time: no new request is taken until the last is through.
//  Insert and delete walk the list up to the position; search walks until
//  a key matches or the list ends. The walk follows one link per cycle
//  through the single read port of the link store.
//  Reset leaves the store ready at once: per-entry valid bits stand for the
//  reset contents. A waiting response does not block the next request.
// ----------------------------------------------------------------------------
module static_linked_list_engine (
    input  logic       clk,
    input  logic       rst_n,
    sll_req_if.sink    request,
    sll_rsp_if.source  response
);

    sll_pkg::dp_cmd_t    cmd;
    sll_pkg::dp_status_t st;

    sll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .st       (st),
        .cmd      (cmd)
    );

    sll_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .in_action   (request.action),
        .in_position (request.position),
        .in_key      (request.key),
        .out_valid   (response.valid),
        .out_ready   (response.ready),
        .out_status  (response.status),
        .out_index   (response.node_index),
        .out_key     (response.node_key),
        .out_link    (response.node_link),
        .out_count   (response.list_count)
    );

endmodule

// ===== rtl/sll_ctrl.sv =====
// ----------------------------------------------------------------------------
// sll_ctrl
// Sequencer: checks each request, walks the list and orders the link writes.
// ----------------------------------------------------------------------------
module sll_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sll_pkg::dp_status_t  st,
    output sll_pkg::dp_cmd_t     cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CHECK     = 4'd1;
    localparam logic [3:0] S_INS_FREE  = 4'd2;
    localparam logic [3:0] S_INS_FNEXT = 4'd3;
    localparam logic [3:0] S_WALK      = 4'd4;
    localparam logic [3:0] S_INS_PREV  = 4'd5;
    localparam logic [3:0] S_INS_ZERO  = 4'd6;
    localparam logic [3:0] S_DEL_GN    = 4'd7;
    localparam logic [3:0] S_DEL_ZN    = 4'd8;
    localparam logic [3:0] S_DEL_GONE  = 4'd9;
    localparam logic [3:0] S_DEL_ZERO  = 4'd10;
    localparam logic [3:0] S_SRCH_FIRST = 4'd11;
    localparam logic [3:0] S_SRCH_CMP  = 4'd12;
    localparam logic [3:0] S_READ_DATA = 4'd13;
    localparam logic [3:0] S_DONE      = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = in_valid;
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                case (st.action)
                    sll_pkg::ACT_INSERT:
                    begin
                        if (st.ins_bad)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = sll_pkg::ST_RANGE;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.link_rd = 1'b1;
                            cmd.rd_sel  = sll_pkg::RA_FREE;
                            state_next  = S_INS_FREE;
                        end
                    end
                    sll_pkg::ACT_DELETE:
                    begin
                        if (st.del_bad)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = sll_pkg::ST_RANGE;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.link_rd = 1'b1;
                            cmd.rd_sel  = sll_pkg::RA_HEAD;
                            cmd.step_op = sll_pkg::SC_LOAD;
                            state_next  = S_WALK;
                        end
                    end
                    sll_pkg::ACT_SEARCH:
                    begin
                        cmd.link_rd = 1'b1;
                        cmd.rd_sel  = sll_pkg::RA_HEAD;
                        cmd.step_op = sll_pkg::SC_CLEAR;
                        state_next  = S_SRCH_FIRST;
                    end
                    default:
                    begin
                        if (st.rd_bad)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = sll_pkg::ST_RANGE;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.link_rd = 1'b1;
                            cmd.key_rd  = 1'b1;
                            cmd.rd_sel  = sll_pkg::RA_POS;
                            state_next  = S_READ_DATA;
                        end
                    end
                endcase
            end
            S_INS_FREE:
            begin
                // read data is the first free node
                if (st.link_zero)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = sll_pkg::ST_FULL;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.node_load = 1'b1;
                    cmd.link_rd   = 1'b1;
                    cmd.rd_sel    = sll_pkg::RA_LINK;
                    state_next    = S_INS_FNEXT;
                end
            end
            S_INS_FNEXT:
            begin
                cmd.aux_load = 1'b1;
                cmd.link_rd  = 1'b1;
                cmd.rd_sel   = sll_pkg::RA_HEAD;
                cmd.step_op  = sll_pkg::SC_LOAD;
                state_next   = S_WALK;
            end
            S_WALK:
            begin
                // read data is the link of the last node visited
                if (!st.step_zero)
                begin
                    cmd.link_rd = 1'b1;
                    cmd.rd_sel  = sll_pkg::RA_LINK;
                    cmd.step_op = sll_pkg::SC_DEC;
                end
                else if (st.action == sll_pkg::ACT_INSERT)
                begin
                    cmd.link_wr   = 1'b1;
                    cmd.wa_sel    = sll_pkg::WA_NODE;
                    cmd.wd_sel    = sll_pkg::WD_LINK;
                    cmd.key_wr    = 1'b1;
                    cmd.prev_load = 1'b1;
                    state_next    = S_INS_PREV;
                end
                else if (st.link_zero)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = sll_pkg::ST_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.node_load = 1'b1;
                    cmd.prev_load = 1'b1;
                    cmd.link_rd   = 1'b1;
                    cmd.rd_sel    = sll_pkg::RA_LINK;
                    state_next    = S_DEL_GN;
                end
            end
            S_INS_PREV:
            begin
                cmd.link_wr = 1'b1;
                cmd.wa_sel  = sll_pkg::WA_PREV;
                cmd.wd_sel  = sll_pkg::WD_NODE;
                state_next  = S_INS_ZERO;
            end
            S_INS_ZERO:
            begin
                cmd.link_wr    = 1'b1;
                cmd.wa_sel     = sll_pkg::WA_FREE;
                cmd.wd_sel     = sll_pkg::WD_AUX;
                cmd.cnt_inc    = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = sll_pkg::ST_OK;
                cmd.res_idx    = sll_pkg::RI_NODE;
                state_next     = S_DONE;
            end
            S_DEL_GN:
            begin
                cmd.aux_load = 1'b1;
                cmd.link_rd  = 1'b1;
                cmd.rd_sel   = sll_pkg::RA_FREE;
                state_next   = S_DEL_ZN;
            end
            S_DEL_ZN:
            begin
                // unlink the node; read data holds the old free head
                cmd.link_wr = 1'b1;
                cmd.wa_sel  = sll_pkg::WA_PREV;
                cmd.wd_sel  = sll_pkg::WD_AUX;
                state_next  = S_DEL_GONE;
            end
            S_DEL_GONE:
            begin
                cmd.link_wr = 1'b1;
                cmd.wa_sel  = sll_pkg::WA_NODE;
                cmd.wd_sel  = sll_pkg::WD_LINK;
                state_next  = S_DEL_ZERO;
            end
            S_DEL_ZERO:
            begin
                cmd.link_wr    = 1'b1;
                cmd.wa_sel     = sll_pkg::WA_FREE;
                cmd.wd_sel     = sll_pkg::WD_NODE;
                cmd.cnt_dec    = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = sll_pkg::ST_OK;
                cmd.res_idx    = sll_pkg::RI_NODE;
                state_next     = S_DONE;
            end
            S_SRCH_FIRST:
            begin
                if (st.link_zero)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = sll_pkg::ST_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.link_rd = 1'b1;
                    cmd.key_rd  = 1'b1;
                    cmd.rd_sel  = sll_pkg::RA_LINK;
                    state_next  = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (st.key_match)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = sll_pkg::ST_OK;
                    cmd.res_idx    = sll_pkg::RI_RDADDR;
                    state_next     = S_DONE;
                end
                else if (st.link_zero || st.step_last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = sll_pkg::ST_OK;
                    state_next     = S_DONE;
                end
                else
                begin
                    cmd.link_rd = 1'b1;
                    cmd.key_rd  = 1'b1;
                    cmd.rd_sel  = sll_pkg::RA_LINK;
                    cmd.step_op = sll_pkg::SC_INC;
                end
            end
            S_READ_DATA:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = sll_pkg::ST_OK;
                cmd.res_idx    = sll_pkg::RI_RDADDR;
                cmd.res_data   = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                cmd.out_load = st.out_free;
                if (st.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sll_datapath.sv =====
// ----------------------------------------------------------------------------
// sll_datapath
// Node store, walk registers, element count and the output register.
// ----------------------------------------------------------------------------
module sll_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sll_pkg::dp_cmd_t              cmd,
    output sll_pkg::dp_status_t           st,
    input  logic [sll_pkg::ACT_W-1:0]     in_action,
    input  logic [sll_pkg::IDX_W-1:0]     in_position,
    input  logic [sll_pkg::KEY_W-1:0]     in_key,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sll_pkg::ST_W-1:0]      out_status,
    output logic [sll_pkg::IDX_W-1:0]     out_index,
    output logic [sll_pkg::KEY_W-1:0]     out_key,
    output logic [sll_pkg::IDX_W-1:0]     out_link,
    output logic [sll_pkg::IDX_W-1:0]     out_count
);

    localparam int IDX_W = sll_pkg::IDX_W;
    localparam int KEY_W = sll_pkg::KEY_W;

    // node store
    logic [IDX_W-1:0]         link_mem [sll_pkg::NODES];
    logic [KEY_W-1:0]         key_mem  [sll_pkg::NODES];
    logic [sll_pkg::NODES-1:0] link_vld_reg;
    logic [sll_pkg::NODES-1:0] key_vld_reg;

    logic [IDX_W-1:0]         link_rd_reg;
    logic [KEY_W-1:0]         key_rd_reg;
    logic                     link_rd_vld_reg;
    logic                     key_rd_vld_reg;
    logic [IDX_W-1:0]         rd_addr_reg;

    // item and walk registers
    logic [sll_pkg::ACT_W-1:0] act_reg;
    logic [IDX_W-1:0]         pos_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [IDX_W-1:0]         node_reg;
    logic [IDX_W-1:0]         prev_reg;
    logic [IDX_W-1:0]         aux_reg;
    logic [IDX_W-1:0]         step_reg;
    logic [IDX_W-1:0]         step_next;
    logic [IDX_W-1:0]         cnt_reg;

    // result staging and output
    logic [sll_pkg::ST_W-1:0] res_status_reg;
    logic [IDX_W-1:0]         res_idx_reg;
    logic [KEY_W-1:0]         res_key_reg;
    logic [IDX_W-1:0]         res_link_reg;
    logic                     out_valid_reg;
    logic [sll_pkg::ST_W-1:0] out_status_reg;
    logic [IDX_W-1:0]         out_index_reg;
    logic [KEY_W-1:0]         out_key_reg;
    logic [IDX_W-1:0]         out_link_reg;
    logic [IDX_W-1:0]         out_count_reg;

    logic [IDX_W-1:0]         link_data;
    logic [KEY_W-1:0]         key_data;
    logic [IDX_W-1:0]         rd_addr;
    logic [IDX_W-1:0]         wr_addr;
    logic [IDX_W-1:0]         wr_data;
    logic [IDX_W-1:0]         res_idx;
    logic                     out_free;

    // never-written entries read as their reset contents
    assign link_data = link_rd_vld_reg ? link_rd_reg : sll_pkg::link_reset(rd_addr_reg);
    assign key_data  = key_rd_vld_reg ? key_rd_reg : '0;

    always_comb
    begin
        case (cmd.rd_sel)
            sll_pkg::RA_FREE: rd_addr = sll_pkg::FREE_NODE;
            sll_pkg::RA_HEAD: rd_addr = sll_pkg::HEAD_NODE;
            sll_pkg::RA_LINK: rd_addr = link_data;
            sll_pkg::RA_POS:  rd_addr = pos_reg;
            default:          rd_addr = sll_pkg::FREE_NODE;
        endcase
    end

    always_comb
    begin
        case (cmd.wa_sel)
            sll_pkg::WA_FREE: wr_addr = sll_pkg::FREE_NODE;
            sll_pkg::WA_NODE: wr_addr = node_reg;
            sll_pkg::WA_PREV: wr_addr = prev_reg;
            default:          wr_addr = sll_pkg::FREE_NODE;
        endcase
    end

    always_comb
    begin
        case (cmd.wd_sel)
            sll_pkg::WD_LINK: wr_data = link_data;
            sll_pkg::WD_NODE: wr_data = node_reg;
            sll_pkg::WD_AUX:  wr_data = aux_reg;
            default:          wr_data = link_data;
        endcase
    end

    always_comb
    begin
        case (cmd.res_idx)
            sll_pkg::RI_ZERO:   res_idx = '0;
            sll_pkg::RI_NODE:   res_idx = node_reg;
            sll_pkg::RI_RDADDR: res_idx = rd_addr_reg;
            default:            res_idx = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.step_op)
            sll_pkg::SC_HOLD:  step_next = step_reg;
            sll_pkg::SC_LOAD:  step_next = pos_reg - IDX_W'(1);
            sll_pkg::SC_CLEAR: step_next = '0;
            sll_pkg::SC_DEC:   step_next = step_reg - IDX_W'(1);
            sll_pkg::SC_INC:   step_next = step_reg + IDX_W'(1);
            default:           step_next = step_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.link_wr)
            link_mem[wr_addr] <= wr_data;
        if (cmd.link_rd)
            link_rd_reg <= link_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_wr)
            key_mem[node_reg] <= key_reg;
        if (cmd.key_rd)
            key_rd_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld_reg    <= '0;
            key_vld_reg     <= '0;
            link_rd_vld_reg <= 1'b0;
            key_rd_vld_reg  <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.link_wr)
                link_vld_reg[wr_addr] <= 1'b1;
            if (cmd.key_wr)
                key_vld_reg[node_reg] <= 1'b1;
            if (cmd.link_rd)
                link_rd_vld_reg <= link_vld_reg[rd_addr];
            if (cmd.key_rd)
                key_rd_vld_reg <= key_vld_reg[rd_addr];
            if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + IDX_W'(1);
            else if (cmd.cnt_dec)
                cnt_reg <= cnt_reg - IDX_W'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg <= in_action;
            pos_reg <= in_position;
            key_reg <= in_key;
        end
        if (cmd.link_rd)
            rd_addr_reg <= rd_addr;
        if (cmd.node_load)
            node_reg <= link_data;
        if (cmd.prev_load)
            prev_reg <= rd_addr_reg;
        if (cmd.aux_load)
            aux_reg <= link_data;
        step_reg <= step_next;
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_idx_reg    <= res_idx;
            res_key_reg    <= cmd.res_data ? key_data : '0;
            res_link_reg   <= cmd.res_data ? link_data : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_idx_reg;
            out_key_reg    <= res_key_reg;
            out_link_reg   <= res_link_reg;
            out_count_reg  <= cnt_reg;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        st.action    = act_reg;
        st.ins_bad   = (pos_reg == '0) ||
                       ({1'b0, pos_reg} > ({1'b0, cnt_reg} + (IDX_W+1)'(1)));
        st.del_bad   = (pos_reg == '0) || (pos_reg > cnt_reg);
        st.rd_bad    = ({1'b0, pos_reg} >= (IDX_W+1)'(sll_pkg::NODES));
        st.link_zero = (link_data == '0);
        st.key_match = (key_data == key_reg);
        st.step_zero = (step_reg == '0);
        st.step_last = (step_reg == sll_pkg::LAST_NODE);
        st.out_free  = out_free;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_index  = out_index_reg;
    assign out_key    = out_key_reg;
    assign out_link   = out_link_reg;
    assign out_count  = out_count_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cnt_reg} <= (IDX_W+1)'(sll_pkg::NODES - 2))
        else $error("list count beyond store capacity");

    a_count_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_inc || cmd.cnt_dec) |-> (cmd.res_load && cmd.res_status == sll_pkg::ST_OK))
        else $error("list count changed without a successful result");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output register overwritten while its item waits");

    a_no_node_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.key_wr |-> (node_reg != sll_pkg::FREE_NODE && node_reg != sll_pkg::HEAD_NODE))
        else $error("key written into a fixed head node");
`endif

endmodule
